@@ design/kbif_pkg.sv @@
// Package for the keyboard interface block: sizes, codes, controller states and the
// command and status structs that pass between the controller and the datapath.
// Depends on nothing.
`timescale 1ns / 1ps

package kbif_pkg;

   // Queue sizing
   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Status byte layout: only the low three bits of the position count
   localparam int         PENDING_BIT  = 0;
   localparam logic [7:0] PENDING_MASK = 8'(1 << (PENDING_BIT % 8));

   // Controller command and configuration byte fields
   localparam logic [7:0] CMD_CONFIGURE    = 8'h60;
   localparam logic [7:0] CFG_DISABLE_MASK = 8'h10;
   localparam logic [7:0] CFG_IRQ_MASK     = 8'h01;

   // Item kinds; code 3 is unused and falls into default arms
   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_READ  = 2'd1,
      REQ_KEY   = 2'd2
   } req_kind_type;

   // Register selects
   typedef enum logic [1:0] {
      REG_RX     = 2'd0,
      REG_STATUS = 2'd1,
      REG_CMD    = 2'd2,
      REG_TX     = 2'd3
   } reg_sel_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load_item;   // capture the accepted item
      logic commit;      // apply an item that needs no dequeue, load the result
      logic pop_commit;  // finish a dequeue, load the result
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic pop_hit;     // held item reads the receive register with keys queued
      logic slot_free;   // result register can take a new result this cycle
   } dp_status_type;

   // Circular pointer step
   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + PTR_W'(1);
      end
      return nxt;
   endfunction

endpackage

@@ design/kbif_ctrl.sv @@
// Controller for the keyboard interface block: accepts items and sequences the
// datapath through execute and dequeue steps. Uses kbif_pkg.
`timescale 1ns / 1ps

module kbif_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  kbif_pkg::dp_status_type status,
   output kbif_pkg::ctrl_cmd_type  cmd
);
   import kbif_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // a dequeue waits in ST_POP for the registered queue read data
            if (status.pop_hit) begin
               state_in = ST_POP;
            end else if (status.slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_POP: begin
            if (status.slot_free) begin
               cmd.pop_commit = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Dequeue step follows the execute step, or itself while the result is stalled
   ap_pop_after_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |-> ($past(state_ff) == ST_EXEC || $past(state_ff) == ST_POP))
      else $error("dequeue step entered from the wrong state");

   // At most one datapath action per cycle
   ap_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_item, cmd.commit, cmd.pop_commit}))
      else $error("controller issued conflicting commands");

   // Dequeue finish only from the dequeue step
   ap_pop_commit_state: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_commit |-> (state_ff == ST_POP))
      else $error("dequeue finish outside the dequeue step");

endmodule

@@ design/kbif_dp.sv @@
// Datapath for the keyboard interface block: item holding registers, keycode queue,
// controller registers and the result register. Uses kbif_pkg.
`timescale 1ns / 1ps

module kbif_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  kbif_pkg::ctrl_cmd_type   cmd,
   output kbif_pkg::dp_status_type  status,
   input  logic [1:0]               req_kind,
   input  logic [1:0]               reg_sel,
   input  logic [7:0]               write_data,
   input  logic [7:0]               keycode,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               read_data,
   output logic                     key_dropped,
   output logic                     data_pending,
   output logic                     irq_enabled
);
   import kbif_pkg::*;

   // Held item
   logic [1:0] kind_ff;
   logic [1:0] sel_ff;
   logic [7:0] wdata_ff;
   logic [7:0] keycode_ff;

   // Queue and controller state
   logic [7:0]       queue_mem [QUEUE_DEPTH];
   logic [7:0]       rd_data_ff;
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       receive_ff, receive_in;
   logic [7:0]       transmit_ff, transmit_in;
   logic [7:0]       command_ff, command_in;
   logic             enabled_ff, enabled_in;
   logic             irq_ff, irq_in;
   logic             pending_ff, pending_in;
   logic             push_en;

   // Result register
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_rdata_ff;
   logic       out_drop_ff;
   logic       out_pend_ff;
   logic       out_irq_ff;
   logic [7:0] rdata;
   logic       dropped;

   // Item capture
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         kind_ff    <= req_kind;
         sel_ff     <= reg_sel;
         wdata_ff   <= write_data;
         keycode_ff <= keycode;
      end
   end

   // Status to the controller
   always_comb begin
      status.pop_hit   = (kind_ff == REQ_READ) && (sel_ff == REG_RX) && (count_ff != '0);
      status.slot_free = !out_valid_ff || rsp_tready;
   end

   // Queue memory: write at the write pointer, registered read at the read pointer
   always_ff @(posedge clock) begin
      if (push_en) begin
         queue_mem[wptr_ff] <= keycode_ff;
      end
      rd_data_ff <= queue_mem[rptr_ff];
   end

   // Item execution
   always_comb begin
      wptr_in     = wptr_ff;
      rptr_in     = rptr_ff;
      count_in    = count_ff;
      receive_in  = receive_ff;
      transmit_in = transmit_ff;
      command_in  = command_ff;
      enabled_in  = enabled_ff;
      irq_in      = irq_ff;
      pending_in  = pending_ff;
      push_en     = 1'b0;
      rdata       = 8'h00;
      dropped     = 1'b0;
      if (cmd.pop_commit) begin
         receive_in = rd_data_ff;
         rptr_in    = next_ptr(rptr_ff);
         count_in   = count_ff - CNT_W'(1);
         pending_in = (count_ff != CNT_W'(1));
         rdata      = rd_data_ff;
      end else if (cmd.commit) begin
         case (kind_ff)
            REQ_WRITE: begin
               if (sel_ff == REG_CMD) begin
                  command_in = wdata_ff;
               end else if (sel_ff == REG_TX) begin
                  transmit_in = wdata_ff;
                  if (command_ff == CMD_CONFIGURE) begin
                     enabled_in = (wdata_ff & CFG_DISABLE_MASK) == 8'h00;
                     irq_in     = (wdata_ff & CFG_IRQ_MASK) != 8'h00;
                  end
               end
            end
            REQ_READ: begin
               // receive read here only with an empty queue
               if (sel_ff == REG_RX) begin
                  rdata      = receive_ff;
                  pending_in = 1'b0;
               end else if (sel_ff == REG_STATUS) begin
                  rdata = pending_ff ? PENDING_MASK : 8'h00;
               end
            end
            REQ_KEY: begin
               if (!enabled_ff || count_ff >= CNT_W'(QUEUE_DEPTH)) begin
                  dropped = 1'b1;
               end else begin
                  push_en    = 1'b1;
                  wptr_in    = next_ptr(wptr_ff);
                  count_in   = count_ff + CNT_W'(1);
                  pending_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Controller state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff     <= '0;
         rptr_ff     <= '0;
         count_ff    <= '0;
         receive_ff  <= 8'h00;
         transmit_ff <= 8'h00;
         command_ff  <= 8'h00;
         enabled_ff  <= 1'b0;
         irq_ff      <= 1'b0;
         pending_ff  <= 1'b0;
      end else begin
         wptr_ff     <= wptr_in;
         rptr_ff     <= rptr_in;
         count_ff    <= count_in;
         receive_ff  <= receive_in;
         transmit_ff <= transmit_in;
         command_ff  <= command_in;
         enabled_ff  <= enabled_in;
         irq_ff      <= irq_in;
         pending_ff  <= pending_in;
      end
   end

   // Result register valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.commit || cmd.pop_commit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (cmd.commit || cmd.pop_commit) begin
         out_rdata_ff <= rdata;
         out_drop_ff  <= dropped;
         out_pend_ff  <= pending_in;
         out_irq_ff   <= irq_in;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign read_data    = out_rdata_ff;
   assign key_dropped  = out_drop_ff;
   assign data_pending = out_pend_ff;
   assign irq_enabled  = out_irq_ff;

   // Pending always mirrors a non-empty queue
   ap_pending_tracks_count: assert property (@(posedge clock) disable iff (reset)
      pending_ff == (count_ff != '0))
      else $error("pending flag out of step with queue fill");

   // Fill never exceeds the depth
   ap_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue fill above depth");

   // A result is never loaded over one that was not taken
   ap_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit || cmd.pop_commit) |-> (!out_valid_ff || rsp_tready))
      else $error("result register overwritten");

endmodule

@@ design/keyboard_interface_fifo_core.sv @@
// Top level of the keyboard interface block with its keycode queue.
// Instantiates kbif_ctrl and kbif_dp; uses kbif_pkg.
//
//   channel   dir   handshake             payload
//   req_      in    req_tvalid/tready     tdata: write_data, keycode
//                                         tuser: req_type, reg_select
//   rsp_      out   rsp_tvalid/tready     tdata: read_data, key_dropped,
//                                                data_pending, irq_enabled
//
// An item goes through accept and execute steps; a receive read that dequeues adds
// a dequeue step for the registered read of the queue memory.
// Synchronous active-high reset clears pointers, fill count and control registers;
// queue contents are not cleared. The result register lets the next item be accepted
// while a result waits; a stalled result holds the next item's execute or dequeue step.
`timescale 1ns / 1ps

module keyboard_interface_fifo_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] write_data, [15:8] keycode
   input  logic [3:0]  req_tuser,   // [1:0] req_type, [3:2] reg_select
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [7:0] read_data, [8] key_dropped,
                                    // [9] data_pending, [10] irq_enabled, [15:11] zero
);
   import kbif_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic [7:0]    read_data;
   logic          key_dropped;
   logic          data_pending;
   logic          irq_enabled;

   kbif_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   kbif_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_kind     (req_tuser[1:0]),
      .reg_sel      (req_tuser[3:2]),
      .write_data   (req_tdata[7:0]),
      .keycode      (req_tdata[15:8]),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .read_data    (read_data),
      .key_dropped  (key_dropped),
      .data_pending (data_pending),
      .irq_enabled  (irq_enabled)
   );

   // Result packing
   assign rsp_tdata = {5'b0, irq_enabled, data_pending, key_dropped, read_data};

endmodule
